@@ hdl/assert_macros.svh @@
// assertion macros used by fpba_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is active
`define FPBA_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define FPBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ hdl/fpba_pkg.sv @@
// types, codes and helpers of the fit policy block allocator
// no dependencies
package fpba_pkg;

    localparam int REQ_W      = 16;
    localparam int FIDX_W     = 6;
    localparam int BIDX_W     = 6;
    localparam int ADDR_OUT_W = 16;
    localparam int SIZE_W     = 17;
    localparam int MODE_W     = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_mode_t;

    typedef enum logic [2:0] {
        STAT_REUSED  = 3'd0,
        STAT_GROWN   = 3'd1,
        STAT_ZERO    = 3'd2,
        STAT_NOSPACE = 3'd3,
        STAT_FREED   = 3'd4,
        STAT_BADFREE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_RD,
        S_SCAN,
        S_DECIDE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [REQ_W-1:0]  req_size;
        logic [FIDX_W-1:0] free_index;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [BIDX_W-1:0]     block_index;
        logic [ADDR_OUT_W-1:0] data_address;
        logic [SIZE_W-1:0]     granted_size;
    } out_item_t;

    function automatic out_item_t make_item(input status_t st,
                                            input logic [BIDX_W-1:0] idx,
                                            input logic [ADDR_OUT_W-1:0] addr,
                                            input logic [SIZE_W-1:0] sz);
        out_item_t r;
        r.status       = st;
        r.block_index  = idx;
        r.data_address = addr;
        r.granted_size = sz;
        return r;
    endfunction

endpackage

@@ hdl/fpba_table_ram.sv @@
// block table memory: one write port, one read port, registered read data
// no dependencies
module fpba_table_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/fpba_ctrl.sv @@
// sequencer of the allocator: table scan, fit choice, table update, result
// depends on fpba_pkg; drives the ports of fpba_table_ram
module fpba_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [fpba_pkg::MODE_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fpba_pkg::in_item_t            s_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output fpba_pkg::out_item_t           res_item,
    output logic                          wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
    output logic [fpba_pkg::SIZE_W+$clog2(HEAP_BYTES):0] wr_data,
    output logic                          rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
    input  logic [fpba_pkg::SIZE_W+$clog2(HEAP_BYTES):0] rd_data
);
    import fpba_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int HT_W   = $clog2(HEAP_BYTES + 1);
    localparam int OFS_W  = $clog2(HEAP_BYTES);
    localparam int ENT_W  = 1 + SIZE_W + OFS_W;
    localparam int FI_W   = (CNT_W > FIDX_W) ? CNT_W : FIDX_W;
    localparam int SUM_W  = ((HT_W > SIZE_W) ? HT_W : SIZE_W) + 1;
    localparam int ADDR_W = ((OFS_W > ADDR_OUT_W) ? OFS_W : ADDR_OUT_W) + 1;

    state_t              state_reg, state_next;
    fit_mode_t           mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HT_W-1:0]     heap_top_reg, heap_top_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                cursor_valid_reg, cursor_valid_next;
    logic [SIZE_W-1:0]   need_reg, need_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                rv_reg, rv_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;
    logic                win_valid_reg, win_valid_next;
    logic [IDX_W-1:0]    win_idx_reg, win_idx_next;
    logic [SIZE_W-1:0]   win_size_reg, win_size_next;
    logic [OFS_W-1:0]    win_ofs_reg, win_ofs_next;
    out_item_t           res_reg, res_next;

    logic                rd_free;
    logic [SIZE_W-1:0]   rd_size;
    logic [OFS_W-1:0]    rd_ofs;
    logic [SIZE_W-1:0]   need_c;
    logic [FI_W-1:0]     fidx_ext;
    logic [IDX_W-1:0]    start_c;
    logic [SUM_W-1:0]    grow_sum;
    logic                issue;
    logic                fits;
    logic                single_hit;

    function automatic logic [ADDR_OUT_W-1:0] data_addr(input logic [OFS_W-1:0] ofs);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ofs) + ADDR_W'(HEADER_BYTES);
        return a[ADDR_OUT_W-1:0];
    endfunction

    function automatic logic [BIDX_W-1:0] index_out(input logic [IDX_W-1:0] i);
        logic [FI_W-1:0] e;
        e = FI_W'(i);
        return e[BIDX_W-1:0];
    endfunction

    assign rd_free = rd_data[ENT_W-1];
    assign rd_size = rd_data[OFS_W +: SIZE_W];
    assign rd_ofs  = rd_data[OFS_W-1:0];

    // round up to a multiple of four
    always_comb begin
        need_c = {1'b0, s_item.req_size} + SIZE_W'(3);
        need_c[1:0] = 2'b00;
    end

    assign fidx_ext = FI_W'(s_item.free_index);
    assign start_c  = (mode_reg == FIT_NEXT && cursor_valid_reg &&
                       CNT_W'(cursor_reg) < count_reg) ? cursor_reg : '0;
    assign grow_sum = SUM_W'(heap_top_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(need_reg);
    assign issue    = (k_reg != count_reg);
    assign fits     = rv_reg && rd_free && (rd_size >= need_reg);
    assign single_hit = (mode_reg == FIT_FIRST) || (mode_reg == FIT_NEXT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            mode_reg         <= FIT_FIRST;
            count_reg        <= '0;
            heap_top_reg     <= '0;
            cursor_reg       <= '0;
            cursor_valid_reg <= 1'b0;
            rv_reg           <= 1'b0;
            win_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            count_reg        <= count_next;
            heap_top_reg     <= heap_top_next;
            cursor_reg       <= cursor_next;
            cursor_valid_reg <= cursor_valid_next;
            rv_reg           <= rv_next;
            win_valid_reg    <= win_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg     <= need_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        ridx_reg     <= ridx_next;
        win_idx_reg  <= win_idx_next;
        win_size_reg <= win_size_next;
        win_ofs_reg  <= win_ofs_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next        = state_reg;
        mode_next         = cfg_valid ? fit_mode_t'(cfg_data) : mode_reg;
        count_next        = count_reg;
        heap_top_next     = heap_top_reg;
        cursor_next       = cursor_reg;
        cursor_valid_next = cursor_valid_reg;
        need_next         = need_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        rv_next           = 1'b0;
        ridx_next         = ridx_reg;
        win_valid_next    = win_valid_reg;
        win_idx_next      = win_idx_reg;
        win_size_next     = win_size_reg;
        win_ofs_next      = win_ofs_reg;
        res_next          = res_reg;
        s_ready           = 1'b0;
        res_valid         = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = j_reg;
        wr_en             = 1'b0;
        wr_addr           = win_idx_reg;
        wr_data           = {1'b0, win_size_reg, win_ofs_reg};

        unique case (state_reg)
            S_IDLE: begin
                s_ready        = 1'b1;
                win_valid_next = 1'b0;
                if (s_valid) begin
                    need_next = need_c;
                    if (s_item.cmd == CMD_FREE) begin
                        if (fidx_ext >= FI_W'(count_reg)) begin
                            res_next   = make_item(STAT_BADFREE, '0, '0, '0);
                            state_next = S_RESP;
                        end else begin
                            rd_en        = 1'b1;
                            rd_addr      = fidx_ext[IDX_W-1:0];
                            win_idx_next = fidx_ext[IDX_W-1:0];
                            state_next   = S_FREE_RD;
                        end
                    end else if (s_item.req_size == '0) begin
                        res_next   = make_item(STAT_ZERO, '0, '0, '0);
                        state_next = S_RESP;
                    end else begin
                        j_next     = start_c;
                        k_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_FREE_RD: begin
                if (rd_free) begin
                    res_next = make_item(STAT_BADFREE, '0, '0, '0);
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = {1'b1, rd_size, rd_ofs};
                    res_next = make_item(STAT_FREED, index_out(win_idx_reg),
                                         data_addr(rd_ofs), rd_size);
                end
                state_next = S_RESP;
            end

            S_SCAN: begin
                // one read issued per cycle, evaluated when its data returns
                if (issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = j_reg;
                    rv_next   = 1'b1;
                    ridx_next = j_reg;
                    k_next    = k_reg + CNT_W'(1);
                    if (CNT_W'(j_reg) + CNT_W'(1) == count_reg) begin
                        j_next = '0;
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                if (fits && (single_hit || !win_valid_reg ||
                             (mode_reg == FIT_BEST && rd_size < win_size_reg) ||
                             (mode_reg == FIT_WORST && rd_size > win_size_reg))) begin
                    win_valid_next = 1'b1;
                    win_idx_next   = ridx_reg;
                    win_size_next  = rd_size;
                    win_ofs_next   = rd_ofs;
                end
                // first and next fit stop at the first hit
                if (fits && single_hit) begin
                    rv_next    = 1'b0;
                    state_next = S_DECIDE;
                end else if (!issue && !rv_reg) begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (win_valid_reg) begin
                    wr_en             = 1'b1;
                    cursor_next       = win_idx_reg;
                    cursor_valid_next = 1'b1;
                    res_next = make_item(STAT_REUSED, index_out(win_idx_reg),
                                         data_addr(win_ofs_reg), win_size_reg);
                end else begin
                    cursor_valid_next = 1'b0;
                    if (count_reg == CNT_W'(MAX_BLOCKS) ||
                        grow_sum > SUM_W'(HEAP_BYTES)) begin
                        res_next = make_item(STAT_NOSPACE, '0, '0, '0);
                    end else begin
                        wr_en         = 1'b1;
                        wr_addr       = count_reg[IDX_W-1:0];
                        wr_data       = {1'b0, need_reg, heap_top_reg[OFS_W-1:0]};
                        count_next    = count_reg + CNT_W'(1);
                        heap_top_next = grow_sum[HT_W-1:0];
                        res_next = make_item(STAT_GROWN, index_out(count_reg[IDX_W-1:0]),
                                             data_addr(heap_top_reg[OFS_W-1:0]), need_reg);
                    end
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_item = res_reg;

endmodule

@@ hdl/fit_policy_block_allocator.sv @@
// top level of the fit policy block allocator: table memory, sequencer, output register
// depends on fpba_pkg, fpba_table_ram and fpba_ctrl
//
// Heap block allocator with first, next, best and worst fit, one item at a time.
// An allocate searches the table before its result reaches the output register: the
// search reads one table entry per cycle through the single read port of the table
// memory, and first and next fit stop at the first hit. A free of a valid index reads
// its table entry; a zero size allocate or a free of an index beyond the table is
// answered without a table read. s_ready is low while an item is at work; the output
// register lets the next item in while the previous result waits. The table memory
// is not cleared after reset: only entries already appended are read.
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fpba_pkg::MODE_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fpba_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fpba_pkg::out_item_t         m_item
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int ENT_W = 1 + SIZE_W + $clog2(HEAP_BYTES);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             res_valid;
    logic             res_ready;
    out_item_t        res_item;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    fpba_table_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ENT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fpba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ hdl/fpba_checker.sv @@
// port level checks of the allocator and the bind that attaches them
// depends on fpba_pkg, assert_macros.svh and fit_policy_block_allocator
`include "assert_macros.svh"

module fpba_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input fpba_pkg::out_item_t m_item
);
    import fpba_pkg::*;

    `FPBA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `FPBA_ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "stalled result changed")

    `FPBA_ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "item taken while another is at work")

    `FPBA_ASSERT_CLK(a_fail_zero, aclk, aresetn, m_valid && (m_item.status == STAT_ZERO || m_item.status == STAT_NOSPACE || m_item.status == STAT_BADFREE) |-> m_item.block_index == '0 && m_item.data_address == '0 && m_item.granted_size == '0, "failure with nonzero fields")

    `FPBA_ASSERT_CLK(a_size_rounded, aclk, aresetn, m_valid && (m_item.status == STAT_REUSED || m_item.status == STAT_GROWN || m_item.status == STAT_FREED) |-> m_item.granted_size[1:0] == 2'b00 && m_item.granted_size != '0, "granted size not a nonzero multiple of four")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ tb/fpba_alloc_checker.sv @@
// result checker of the fit policy block allocator: tracks the heap table from the
// accepted items and compares every result item with its predicted value
// depends on fpba_pkg
module fpba_alloc_checker #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [fpba_pkg::MODE_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  fpba_pkg::in_item_t          s_item,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  fpba_pkg::out_item_t         m_item,
    output int                          error_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;

    int        blk_size   [MAX_BLOCKS];
    int        blk_offset [MAX_BLOCKS];
    bit        blk_free   [MAX_BLOCKS];
    int        blk_count;
    int        heap_top;
    int        cursor;
    bit        cursor_ok;
    fit_mode_t mode;
    out_item_t expected_grants[$];

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [SIZE_W-1:0] got,
                                 input logic [SIZE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // index of the free block chosen under the current policy, -1 when none fits
    function automatic int pick_free_block(input int need);
        int win;
        int best;
        int start;
        int j;
        int k;
        int i;
        win  = -1;
        best = 0;
        if (mode == FIT_NEXT) begin
            start = (cursor_ok && cursor < blk_count) ? cursor : 0;
            for (k = 0; k < blk_count; k++) begin
                j = start + k;
                if (j >= blk_count) j -= blk_count;
                if (blk_free[j] && blk_size[j] >= need) return j;
            end
            return -1;
        end
        for (i = 0; i < blk_count; i++) begin
            if (!blk_free[i] || blk_size[i] < need) continue;
            if (mode == FIT_FIRST) return i;
            // strict compares keep the earliest block on a tie
            if (win < 0 || (mode == FIT_BEST && blk_size[i] - need < best) ||
                (mode == FIT_WORST && blk_size[i] - need > best)) begin
                win  = i;
                best = blk_size[i] - need;
            end
        end
        return win;
    endfunction

    task automatic apply_heap_request(input in_item_t req, output out_item_t res);
        int need;
        int hit;
        int idx;
        res = '0;
        if (req.cmd == CMD_FREE) begin
            idx = int'(req.free_index);
            if (idx >= blk_count || blk_free[idx]) begin
                res.status = STAT_BADFREE;
            end else begin
                blk_free[idx]    = 1'b1;
                res.status       = STAT_FREED;
                res.block_index  = req.free_index;
                res.data_address = ADDR_OUT_W'(blk_offset[idx] + HEADER_BYTES);
                res.granted_size = SIZE_W'(blk_size[idx]);
            end
        end else if (req.req_size == '0) begin
            res.status = STAT_ZERO;
        end else begin
            need = (int'(req.req_size) + 3) & ~3;
            hit  = pick_free_block(need);
            if (hit >= 0) begin
                blk_free[hit]    = 1'b0;
                cursor           = hit;
                cursor_ok        = 1'b1;
                res.status       = STAT_REUSED;
                res.block_index  = BIDX_W'(hit);
                res.data_address = ADDR_OUT_W'(blk_offset[hit] + HEADER_BYTES);
                res.granted_size = SIZE_W'(blk_size[hit]);
            end else begin
                cursor_ok = 1'b0;
                if (blk_count >= MAX_BLOCKS || heap_top + HEADER_BYTES + need > HEAP_BYTES) begin
                    res.status = STAT_NOSPACE;
                end else begin
                    blk_size[blk_count]   = need;
                    blk_offset[blk_count] = heap_top;
                    blk_free[blk_count]   = 1'b0;
                    res.status            = STAT_GROWN;
                    res.block_index       = BIDX_W'(blk_count);
                    res.data_address      = ADDR_OUT_W'(heap_top + HEADER_BYTES);
                    res.granted_size      = SIZE_W'(need);
                    blk_count++;
                    heap_top += HEADER_BYTES + need;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t next_grant;
        if (!aresetn) begin
            foreach (blk_free[n]) blk_free[n] = 1'b0;
            blk_count = 0;
            heap_top  = 0;
            cursor    = 0;
            cursor_ok = 1'b0;
            mode      = FIT_FIRST;
            expected_grants.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d index %0d",
                                              m_item.status, m_item.block_index));
                end else begin
                    want = expected_grants.pop_front();
                    compare_field("status", SIZE_W'(m_item.status), SIZE_W'(want.status));
                    compare_field("block_index", SIZE_W'(m_item.block_index),
                                  SIZE_W'(want.block_index));
                    compare_field("data_address", SIZE_W'(m_item.data_address),
                                  SIZE_W'(want.data_address));
                    compare_field("granted_size", m_item.granted_size, want.granted_size);
                end
            end
            if (cfg_valid && cfg_ready) mode = fit_mode_t'(cfg_data);
            if (s_valid && s_ready) begin
                apply_heap_request(s_item, next_grant);
                expected_grants.push_back(next_grant);
            end
        end
        pending_count = expected_grants.size();
    end

endmodule

@@ tb/tb_fit_policy_block_allocator.sv @@
// top of the allocator testbench: clock, reset, fit mode writes and request items
// under varying idle and stall patterns; depends on fpba_pkg, the allocator and
// fpba_alloc_checker
module tb_fit_policy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MODE_W-1:0]   cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_item    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_item;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int known_blocks = 0;
    int error_count;
    int pending_count;

    fit_policy_block_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    fpba_alloc_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // keeps most frees aimed at blocks that exist
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_item.status == STAT_GROWN) begin
            known_blocks <= int'(m_item.block_index) + 1;
        end
    end

    function automatic in_item_t request(input logic cmd, input logic [REQ_W-1:0] size,
                                         input logic [FIDX_W-1:0] idx);
        in_item_t r;
        r.cmd        = cmd;
        r.req_size   = size;
        r.free_index = idx;
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int pick;
        r.cmd        = ($urandom_range(99) < 45) ? CMD_FREE : CMD_ALLOC;
        r.req_size   = REQ_W'($urandom);
        r.free_index = FIDX_W'($urandom);
        if (r.cmd == CMD_ALLOC) begin
            pick = $urandom_range(99);
            if (pick < 2) r.req_size = '0;
            else if (pick < 80) r.req_size = REQ_W'($urandom_range(128, 1));
            else if (pick < 95) r.req_size = REQ_W'($urandom_range(2048, 129));
        end else if (known_blocks > 0 && $urandom_range(99) < 88) begin
            r.free_index = FIDX_W'($urandom_range(known_blocks - 1));
        end
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
    endtask

    task automatic write_fit_mode(input fit_mode_t mode);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_fit_mode(FIT_FIRST);
        send_request(request(CMD_ALLOC, 16'd0, 6'd63));
        send_request(request(CMD_FREE, 16'hFFFF, 6'd0));   // empty table
        send_request(request(CMD_ALLOC, 16'd1, 6'd0));
        send_request(request(CMD_ALLOC, 16'd100, 6'd0));
        send_request(request(CMD_ALLOC, 16'd4, 6'd0));
        send_request(request(CMD_ALLOC, 16'd200, 6'd0));
        send_request(request(CMD_FREE, 16'd0, 6'd0));
        send_request(request(CMD_FREE, 16'd0, 6'd0));      // double free
        send_request(request(CMD_FREE, 16'd0, 6'd63));
        send_request(request(CMD_FREE, 16'd0, 6'd4));      // one past the last block
        send_request(request(CMD_FREE, 16'd0, 6'd2));
        send_request(request(CMD_ALLOC, 16'd3, 6'd0));
        send_request(request(CMD_FREE, 16'd0, 6'd1));
        send_request(request(CMD_FREE, 16'd0, 6'd3));
        send_request(request(CMD_ALLOC, 16'd50, 6'd0));    // reuse keeps the full size
        send_request(request(CMD_ALLOC, 16'hFFFF, 6'd0));  // heap overflow
        send_request(request(CMD_ALLOC, 16'hFFFD, 6'd0));
        send_request(request(CMD_ALLOC, 16'd200, 6'd0));
        send_request(request(CMD_ALLOC, 16'd2, 6'd0));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            write_fit_mode(fit_mode_t'(phase % 4));
            case ((phase + phase / 4) % 4)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 61;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 61;
                end
                default: begin
                    gap_pct   = 7;
                    stall_pct = 7;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_table_ram.sv
hdl/fpba_ctrl.sv
hdl/fit_policy_block_allocator.sv
hdl/fpba_checker.sv
tb/fpba_alloc_checker.sv
tb/tb_fit_policy_block_allocator.sv
